FILE: hw/rtl/scaled_arithmetic_unit_macros.svh
// assertion macros for the scaled arithmetic unit
`ifndef SCALED_ARITHMETIC_UNIT_MACROS_SVH
`define SCALED_ARITHMETIC_UNIT_MACROS_SVH

// same-cycle implication, checked at every rising edge outside reset
`define SCAU_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SCAU_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/scau_pkg.sv
// shared types and constants of the scaled arithmetic unit
`default_nettype none

package scau_pkg;

  localparam int unsigned HALF_SHIFT = 15;
  localparam logic [15:0] HALF_UNIT  = 16'o100000;

  // radix-2 divider geometry
  localparam int unsigned DIV_DVD_W = 48;
  localparam int unsigned DIV_DSR_W = 32;
  localparam int unsigned DIV_CNT_W = 6;
  localparam logic [DIV_CNT_W-1:0] DIV_BITS_WIDE = 6'd48;
  localparam logic [DIV_CNT_W-1:0] DIV_BITS_WORD = 6'd32;

  typedef enum logic [1:0] {
    CMD_MULT_ADD  = 2'd0,
    CMD_X_OVER_N  = 2'd1,
    CMD_XN_OVER_D = 2'd2,
    CMD_NONE      = 2'd3
  } cmd_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_MUL_A,
    S_DIV_X,
    S_WAIT_X,
    S_MUL_T,
    S_MUL_U,
    S_CALC_U,
    S_DIV_U,
    S_WAIT_U,
    S_CALC_V,
    S_DIV_V,
    S_WAIT_V,
    S_FIN
  } state_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL_A,
    OP_MUL_T,
    OP_MUL_U,
    OP_CALC_U,
    OP_DIV_X,
    OP_DIV_U,
    OP_CALC_V,
    OP_DIV_V,
    OP_FIN
  } dp_op_e;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [31:0] x_value;
    logic signed [31:0] multiplier;
    logic signed [31:0] addend;
    logic [30:0]        answer_bound;
    logic [16:0]        divisor;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] result;
    logic signed [31:0] remainder_out;
    logic               op_error;
    logic               error_seen;
  } out_item_t;

  typedef struct packed {
    dp_op_e op;
  } ctrl_t;

  typedef struct packed {
    cmd_e cmd;
    logic zero_div;
    logic div_done;
  } status_t;

endpackage

`default_nettype wire

FILE: hw/rtl/scau_div.sv
// radix-2 restoring divider, one quotient bit per cycle
`default_nettype none

`include "scaled_arithmetic_unit_macros.svh"

module scau_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [scau_pkg::DIV_DVD_W-1:0]      dividend_i,
  input  logic [scau_pkg::DIV_DSR_W-1:0]      divisor_i,
  input  logic [scau_pkg::DIV_CNT_W-1:0]      count_i,
  output logic                                done_o,
  output logic [scau_pkg::DIV_DVD_W-1:0]      quo_o,
  output logic [scau_pkg::DIV_DSR_W-1:0]      rem_o
);

  logic                               busy_q, busy_d;
  logic [scau_pkg::DIV_CNT_W-1:0]     cnt_q, cnt_d;
  logic [scau_pkg::DIV_DVD_W-1:0]     dvd_q, quo_q;
  logic [scau_pkg::DIV_DSR_W-1:0]     dsr_q, rem_q;
  logic [scau_pkg::DIV_DSR_W:0]       part;
  logic [scau_pkg::DIV_DSR_W+1:0]     diff;
  logic                               fits;

  // next dividend bit joins the partial remainder
  assign part = {rem_q, dvd_q[scau_pkg::DIV_DVD_W-1]};
  assign diff = {1'b0, part} - {2'b00, dsr_q};
  assign fits = ~diff[scau_pkg::DIV_DSR_W+1];

  assign done_o = busy_q && (cnt_q == scau_pkg::DIV_CNT_W'(1));
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = count_i;
    end else if (busy_q) begin
      cnt_d  = cnt_q - scau_pkg::DIV_CNT_W'(1);
      busy_d = (cnt_q != scau_pkg::DIV_CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dsr_q <= divisor_i;
      quo_q <= '0;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[scau_pkg::DIV_DVD_W-2:0], 1'b0};
      quo_q <= {quo_q[scau_pkg::DIV_DVD_W-2:0], fits};
      rem_q <= fits ? diff[scau_pkg::DIV_DSR_W-1:0] : part[scau_pkg::DIV_DSR_W-1:0];
    end
  end

  `SCAU_ASSERT_IMP(a_start_when_free, clk_i, rst_ni, start_i, !busy_q,
                   "divider started while busy")
  `SCAU_ASSERT_NXT(a_start_loads, clk_i, rst_ni, start_i,
                   busy_q && (cnt_q == $past(count_i)), "divider did not load its count")
  `SCAU_ASSERT_NXT(a_done_frees, clk_i, rst_ni, done_o, !busy_q,
                   "divider still busy after its last step")

endmodule

`default_nettype wire

FILE: hw/rtl/scau_dp.sv
// datapath: operand registers, shared multiplier, divider and result registers
`default_nettype none

module scau_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  scau_pkg::ctrl_t      ctrl_i,
  input  scau_pkg::in_item_t   in_item_i,
  output scau_pkg::status_t    stat_o,
  output scau_pkg::out_item_t  out_item_o
);

  // operands
  logic [1:0]         cmd_q;
  logic signed [31:0] x_q, n_q, y_q;
  logic [30:0]        bound_q;
  logic [16:0]        d_q;
  scau_pkg::cmd_e     cmd_w;

  // intermediates
  logic signed [63:0] prod_q;
  logic signed [33:0] lim_a_q, lim_b_q;
  logic signed [47:0] t_q;
  logic signed [48:0] u_q, u_d;
  logic signed [15:0] tmod_q, tmod_d;
  logic signed [32:0] v_q, v_d;
  logic [16:0]        uq_lo_q, uq_lo_d;
  logic               big_q, big_d;

  // results and kept state
  logic [31:0]        res_q, res_d;
  logic               err_q, err_d;
  logic [31:0]        remainder_q, remainder_d;
  logic               sticky_q;

  logic [31:0]        x_abs, n_abs;
  logic               zero_div;

  // multiplier
  logic signed [32:0] mul_a;
  logic signed [64:0] mul_p;

  // multiply-add bound check
  logic signed [33:0] a_w, b_w, nabs_s, lim_a_w, lim_b_w;
  logic signed [63:0] lim_a_x, lim_b_x, prod_neg;
  logic               mac_ok;
  logic [31:0]        mac_res;

  // high part of x*n/d
  logic signed [47:0] t_neg;
  logic [32:0]        tdiv_mag;
  logic signed [48:0] tdiv;
  logic signed [48:0] u_neg;
  logic [47:0]        u_abs;
  logic signed [17:0] ur_s;
  logic signed [32:0] v_neg;
  logic [31:0]        v_abs;

  // final step
  logic [31:0]        q_word, r_word, q_neg, r_neg, xn_val;

  // divider port
  logic                                 div_start, div_done;
  logic [scau_pkg::DIV_DVD_W-1:0]       div_dvd, div_quo;
  logic [scau_pkg::DIV_DSR_W-1:0]       div_dsr, div_rem;
  logic [scau_pkg::DIV_CNT_W-1:0]       div_cnt;

  assign cmd_w = scau_pkg::cmd_e'(cmd_q);
  assign x_abs = x_q[31] ? (~x_q + 32'd1) : x_q;
  assign n_abs = n_q[31] ? (~n_q + 32'd1) : n_q;

  assign zero_div = ((cmd_w == scau_pkg::CMD_X_OVER_N) && (n_q == '0)) ||
                    ((cmd_w == scau_pkg::CMD_XN_OVER_D) && (d_q == '0));

  always_comb begin
    unique case (ctrl_i.op)
      scau_pkg::OP_MUL_A: mul_a = {x_q[31], x_q};
      scau_pkg::OP_MUL_T: mul_a = {18'd0, x_abs[scau_pkg::HALF_SHIFT-1:0]};
      scau_pkg::OP_MUL_U: mul_a = {16'd0, x_abs[31:scau_pkg::HALF_SHIFT]};
      default:            mul_a = '0;
    endcase
  end

  assign mul_p = mul_a * n_q;

  // limits for n*x against bound-y and bound+y, truncating division folded in
  assign a_w     = $signed({3'b000, bound_q}) - $signed({{2{y_q[31]}}, y_q});
  assign b_w     = $signed({3'b000, bound_q}) + $signed({{2{y_q[31]}}, y_q});
  assign nabs_s  = $signed({2'b00, n_abs});
  assign lim_a_w = a_w[33] ? (a_w + nabs_s - 34'sd1) : a_w;
  assign lim_b_w = b_w[33] ? (b_w + nabs_s - 34'sd1) : b_w;

  assign lim_a_x  = $signed({{30{lim_a_q[33]}}, lim_a_q});
  assign lim_b_x  = $signed({{30{lim_b_q[33]}}, lim_b_q});
  assign prod_neg = -prod_q;
  assign mac_ok   = (prod_q <= lim_a_x) && (prod_neg <= lim_b_x);
  assign mac_res  = prod_q[31:0] + y_q;

  // t/32768 and t%32768 with truncation toward zero
  assign t_neg    = -t_q;
  assign tdiv_mag = t_q[47] ? t_neg[47:scau_pkg::HALF_SHIFT] : t_q[47:scau_pkg::HALF_SHIFT];
  assign tdiv     = t_q[47] ? -$signed({16'd0, tdiv_mag}) : $signed({16'd0, tdiv_mag});
  assign tmod_d   = t_q[47] ? -$signed({1'b0, t_neg[scau_pkg::HALF_SHIFT-1:0]})
                            : $signed({1'b0, t_q[scau_pkg::HALF_SHIFT-1:0]});
  assign u_d      = $signed(prod_q[48:0]) + tdiv;

  assign u_neg = -u_q;
  assign u_abs = u_q[48] ? u_neg[47:0] : u_q[47:0];

  // u/d and u%d back to signed, then v = (u%d)*32768 + t%32768
  assign big_d   = !u_q[48] && (div_quo >= {32'd0, scau_pkg::HALF_UNIT});
  assign uq_lo_d = u_q[48] ? (~div_quo[16:0] + 17'd1) : div_quo[16:0];
  assign ur_s    = u_q[48] ? -$signed({1'b0, div_rem[16:0]}) : $signed({1'b0, div_rem[16:0]});
  assign v_d     = $signed({ur_s, 15'd0}) + $signed({{17{tmod_q[15]}}, tmod_q});

  assign v_neg = -v_q;
  assign v_abs = v_q[32] ? v_neg[31:0] : v_q[31:0];

  always_comb begin
    div_start = 1'b0;
    div_dvd   = '0;
    div_dsr   = '0;
    div_cnt   = '0;
    unique case (ctrl_i.op)
      scau_pkg::OP_DIV_X: begin
        div_start = 1'b1;
        div_dvd   = {x_abs, 16'd0};
        div_dsr   = n_abs;
        div_cnt   = scau_pkg::DIV_BITS_WORD;
      end
      scau_pkg::OP_DIV_U: begin
        div_start = 1'b1;
        div_dvd   = u_abs;
        div_dsr   = {15'd0, d_q};
        div_cnt   = scau_pkg::DIV_BITS_WIDE;
      end
      scau_pkg::OP_DIV_V: begin
        div_start = 1'b1;
        div_dvd   = {v_abs, 16'd0};
        div_dsr   = {15'd0, d_q};
        div_cnt   = scau_pkg::DIV_BITS_WORD;
      end
      default: begin
      end
    endcase
  end

  scau_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dsr),
    .count_i    (div_cnt),
    .done_o     (div_done),
    .quo_o      (div_quo),
    .rem_o      (div_rem)
  );

  assign q_word = div_quo[31:0];
  assign r_word = div_rem;
  assign q_neg  = ~q_word + 32'd1;
  assign r_neg  = ~r_word + 32'd1;
  assign xn_val = big_q ? u_q[31:0]
                        : ({uq_lo_q, 15'd0} + (v_q[32] ? q_neg : q_word));

  always_comb begin
    res_d       = '0;
    err_d       = 1'b0;
    remainder_d = remainder_q;
    if (zero_div) begin
      err_d       = 1'b1;
      remainder_d = x_q;
    end else begin
      unique case (cmd_w)
        scau_pkg::CMD_MULT_ADD: begin
          if (n_q == '0) begin
            res_d = y_q;
          end else if (mac_ok) begin
            res_d = mac_res;
          end else begin
            err_d = 1'b1;
          end
        end
        scau_pkg::CMD_X_OVER_N: begin
          res_d       = (x_q[31] ^ n_q[31]) ? q_neg : q_word;
          remainder_d = x_q[31] ? r_neg : r_word;
        end
        scau_pkg::CMD_XN_OVER_D: begin
          err_d       = big_q;
          res_d       = x_q[31] ? (~xn_val + 32'd1) : xn_val;
          remainder_d = (x_q[31] ^ v_q[32]) ? r_neg : r_word;
        end
        scau_pkg::CMD_NONE: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      remainder_q <= '0;
      sticky_q    <= 1'b0;
    end else if (ctrl_i.op == scau_pkg::OP_FIN) begin
      remainder_q <= remainder_d;
      sticky_q    <= sticky_q | err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (ctrl_i.op)
      scau_pkg::OP_LOAD: begin
        cmd_q   <= in_item_i.command;
        x_q     <= in_item_i.x_value;
        n_q     <= in_item_i.multiplier;
        y_q     <= in_item_i.addend;
        bound_q <= in_item_i.answer_bound;
        d_q     <= in_item_i.divisor;
      end
      scau_pkg::OP_MUL_A: begin
        prod_q  <= mul_p[63:0];
        lim_a_q <= lim_a_w;
        lim_b_q <= lim_b_w;
      end
      scau_pkg::OP_MUL_T: t_q    <= mul_p[47:0];
      scau_pkg::OP_MUL_U: prod_q <= mul_p[63:0];
      scau_pkg::OP_CALC_U: begin
        u_q    <= u_d;
        tmod_q <= tmod_d;
      end
      scau_pkg::OP_CALC_V: begin
        v_q     <= v_d;
        big_q   <= big_d;
        uq_lo_q <= uq_lo_d;
      end
      scau_pkg::OP_FIN: begin
        res_q <= res_d;
        err_q <= err_d;
      end
      default: begin
      end
    endcase
  end

  assign stat_o.cmd      = cmd_w;
  assign stat_o.zero_div = zero_div;
  assign stat_o.div_done = div_done;

  assign out_item_o.result        = res_q;
  assign out_item_o.remainder_out = remainder_q;
  assign out_item_o.op_error      = err_q;
  assign out_item_o.error_seen    = sticky_q;

endmodule

`default_nettype wire

FILE: hw/rtl/scau_ctrl.sv
// controller: sequences one item through the datapath and runs both handshakes
`default_nettype none

`include "scaled_arithmetic_unit_macros.svh"

module scau_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  scau_pkg::status_t  stat_i,
  output scau_pkg::ctrl_t    ctrl_o
);

  scau_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;
  logic             slot_free;

  // result register may be reloaded when empty or drained this cycle
  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      scau_pkg::S_IDLE: begin
        if (in_valid_i) begin
          state_d = scau_pkg::S_DISPATCH;
        end
      end
      scau_pkg::S_DISPATCH: begin
        if (stat_i.zero_div) begin
          state_d = scau_pkg::S_FIN;
        end else begin
          unique case (stat_i.cmd)
            scau_pkg::CMD_MULT_ADD:  state_d = scau_pkg::S_MUL_A;
            scau_pkg::CMD_X_OVER_N:  state_d = scau_pkg::S_DIV_X;
            scau_pkg::CMD_XN_OVER_D: state_d = scau_pkg::S_MUL_T;
            scau_pkg::CMD_NONE:      state_d = scau_pkg::S_FIN;
          endcase
        end
      end
      scau_pkg::S_MUL_A:  state_d = scau_pkg::S_FIN;
      scau_pkg::S_DIV_X:  state_d = scau_pkg::S_WAIT_X;
      scau_pkg::S_WAIT_X: begin
        if (stat_i.div_done) begin
          state_d = scau_pkg::S_FIN;
        end
      end
      scau_pkg::S_MUL_T:  state_d = scau_pkg::S_MUL_U;
      scau_pkg::S_MUL_U:  state_d = scau_pkg::S_CALC_U;
      scau_pkg::S_CALC_U: state_d = scau_pkg::S_DIV_U;
      scau_pkg::S_DIV_U:  state_d = scau_pkg::S_WAIT_U;
      scau_pkg::S_WAIT_U: begin
        if (stat_i.div_done) begin
          state_d = scau_pkg::S_CALC_V;
        end
      end
      scau_pkg::S_CALC_V: state_d = scau_pkg::S_DIV_V;
      scau_pkg::S_DIV_V:  state_d = scau_pkg::S_WAIT_V;
      scau_pkg::S_WAIT_V: begin
        if (stat_i.div_done) begin
          state_d = scau_pkg::S_FIN;
        end
      end
      scau_pkg::S_FIN: begin
        if (slot_free) begin
          state_d = scau_pkg::S_IDLE;
        end
      end
      default: state_d = scau_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o.op   = scau_pkg::OP_NONE;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      scau_pkg::S_IDLE: begin
        if (in_valid_i) begin
          ctrl_o.op = scau_pkg::OP_LOAD;
        end
      end
      scau_pkg::S_MUL_A:  ctrl_o.op = scau_pkg::OP_MUL_A;
      scau_pkg::S_DIV_X:  ctrl_o.op = scau_pkg::OP_DIV_X;
      scau_pkg::S_MUL_T:  ctrl_o.op = scau_pkg::OP_MUL_T;
      scau_pkg::S_MUL_U:  ctrl_o.op = scau_pkg::OP_MUL_U;
      scau_pkg::S_CALC_U: ctrl_o.op = scau_pkg::OP_CALC_U;
      scau_pkg::S_DIV_U:  ctrl_o.op = scau_pkg::OP_DIV_U;
      scau_pkg::S_CALC_V: ctrl_o.op = scau_pkg::OP_CALC_V;
      scau_pkg::S_DIV_V:  ctrl_o.op = scau_pkg::OP_DIV_V;
      scau_pkg::S_FIN: begin
        if (slot_free) begin
          ctrl_o.op   = scau_pkg::OP_FIN;
          out_valid_d = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= scau_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == scau_pkg::S_IDLE);
  assign out_valid_o = out_valid_q;

  `SCAU_ASSERT_IMP(a_fin_slot_free, clk_i, rst_ni, ctrl_o.op == scau_pkg::OP_FIN,
                   !out_valid_q || out_ready_i, "result register overwritten before transfer")
  `SCAU_ASSERT_NXT(a_accept_dispatch, clk_i, rst_ni, in_valid_i && in_ready_o,
                   state_q == scau_pkg::S_DISPATCH, "input transfer not followed by dispatch")
  `SCAU_ASSERT_IMP(a_valid_from_fin, clk_i, rst_ni, $rose(out_valid_q),
                   $past(state_q) == scau_pkg::S_FIN, "result shown without a finish step")

endmodule

`default_nettype wire

FILE: hw/rtl/scaled_arithmetic_unit.sv
// scaled arithmetic unit for 16.16 values: multiply-add, divide by n, x*n/d with remainder
// a zero divisor or the unused command goes straight from dispatch to the finish step;
// one item is worked on at a time, and the next is taken in the cycle after the result
// is registered, even while that result waits downstream
// the radix-2 divider sets the rate: one quotient bit per cycle, 48 for u/d and 32 for the rest
// reset clears the sticky error, the stored remainder, the sequencer and the output valid
`default_nettype none

module scaled_arithmetic_unit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  scau_pkg::in_item_t   in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output scau_pkg::out_item_t  out_item_o
);

  scau_pkg::ctrl_t   ctrl;
  scau_pkg::status_t stat;

  scau_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  scau_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .in_item_i  (in_item_i),
    .stat_o     (stat),
    .out_item_o (out_item_o)
  );

endmodule

`default_nettype wire

FILE: tb/tb_scaled_arithmetic_unit.sv
// self-checking testbench for the scaled arithmetic unit
`default_nettype none

module tb_scaled_arithmetic_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint HALF_SCALE     = 32768;
  localparam int     WATCHDOG_LIMIT = 3000;
  localparam int     HOLD_OFF_LEN   = 400;
  localparam int     DRAIN_CYCLES   = 120;

  logic                clk = 1'b0;
  logic                rst_ni;
  logic                in_valid;
  logic                in_ready;
  scau_pkg::in_item_t  in_item;
  logic                out_valid;
  logic                out_ready;
  scau_pkg::out_item_t out_item;

  // predictor state
  logic                exp_sticky_error;
  logic [31:0]         exp_remainder;
  scau_pkg::out_item_t pending_results[$];

  int fail_count;
  int idle_cycles;
  int hold_off_cycles;
  bit no_idle;

  scaled_arithmetic_unit uut (
    .clk_i      (clk),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_item_o (out_item)
  );

  always #4 clk = ~clk;

  // expected result of one command; updates the predicted sticky flag and remainder
  function automatic scau_pkg::out_item_t predict_scaled_op(scau_pkg::in_item_t it);
    longint              x, n, y, bound, d, res, q, r, t, u, v;
    bit                  err, neg;
    scau_pkg::out_item_t o;
    x     = longint'(it.x_value);
    n     = longint'(it.multiplier);
    y     = longint'(it.addend);
    bound = longint'(it.answer_bound);
    d     = longint'(it.divisor);
    res   = 0;
    err   = 1'b0;
    neg   = 1'b0;
    case (scau_pkg::cmd_e'(it.command))
      scau_pkg::CMD_MULT_ADD: begin
        if (n < 0) begin
          x = -x;
          n = -n;
        end
        if (n == 0) begin
          res = y;
        end else if (x <= (bound - y) / n && -x <= (bound + y) / n) begin
          res = n * x + y;
        end else begin
          err = 1'b1;
        end
      end
      scau_pkg::CMD_X_OVER_N: begin
        if (n == 0) begin
          err           = 1'b1;
          exp_remainder = x[31:0];
        end else begin
          if (n < 0) begin
            x   = -x;
            n   = -n;
            neg = 1'b1;
          end
          if (x >= 0) begin
            q = x / n;
            r = x % n;
          end else begin
            q = -((-x) / n);
            r = -((-x) % n);
          end
          if (neg) r = -r;
          exp_remainder = r[31:0];
          res           = q;
        end
      end
      scau_pkg::CMD_XN_OVER_D: begin
        if (d == 0) begin
          err           = 1'b1;
          exp_remainder = x[31:0];
        end else begin
          if (x < 0) begin
            x   = -x;
            neg = 1'b1;
          end
          // split |x| into its low 15 bits and the bits above them so the partial products stay in range
          t = (x % HALF_SCALE) * n;
          u = (x / HALF_SCALE) * n + t / HALF_SCALE;
          v = (u % d) * HALF_SCALE + t % HALF_SCALE;
          if (u / d >= HALF_SCALE) err = 1'b1;
          else u = HALF_SCALE * (u / d) + v / d;
          r = v % d;
          if (neg) begin
            r = -r;
            u = -u;
          end
          exp_remainder = r[31:0];
          res           = u;
        end
      end
      default: ;
    endcase
    if (err) exp_sticky_error = 1'b1;
    o.result        = res[31:0];
    o.remainder_out = exp_remainder;
    o.op_error      = err;
    o.error_seen    = exp_sticky_error;
    return o;
  endfunction

  function automatic int unsigned draw_wait();
    return no_idle ? 0 : $urandom_range(0, 6);
  endfunction

  function automatic scau_pkg::in_item_t make_item(scau_pkg::cmd_e cmd, logic [31:0] x,
                                                   logic [31:0] n, logic [31:0] y,
                                                   int bound, int d);
    scau_pkg::in_item_t it;
    it.command      = cmd;
    it.x_value      = x;
    it.multiplier   = n;
    it.addend       = y;
    it.answer_bound = 31'(bound);
    it.divisor      = 17'(d);
    return it;
  endfunction

  function automatic logic [31:0] rand_operand();
    logic [31:0] val;
    case ($urandom_range(0, 9))
      0: val = 32'h8000_0000;
      1: val = 32'h7fff_ffff;
      2: val = $urandom_range(0, 3) - 1;
      3, 4: val = $urandom();
      5, 6: val = $urandom_range(0, 32'h00ff_ffff);
      default: val = $urandom_range(0, 1000);
    endcase
    if (val[31] == 1'b0 && $urandom_range(0, 1)) val = -val;
    return val;
  endfunction

  function automatic scau_pkg::in_item_t rand_item();
    scau_pkg::in_item_t it;
    int unsigned        pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) it.command = scau_pkg::CMD_NONE;
    else if (pick <= 6) it.command = scau_pkg::CMD_MULT_ADD;
    else if (pick <= 12) it.command = scau_pkg::CMD_X_OVER_N;
    else it.command = scau_pkg::CMD_XN_OVER_D;
    it.x_value = rand_operand();
    it.addend  = rand_operand();
    if (it.command == scau_pkg::CMD_XN_OVER_D && $urandom_range(0, 9) < 7)
      it.multiplier = $urandom_range(0, 65536);
    else if (it.command == scau_pkg::CMD_MULT_ADD && $urandom_range(0, 9) < 6)
      it.multiplier = $urandom_range(0, 2000) - 1000;
    else
      it.multiplier = rand_operand();
    case ($urandom_range(0, 5))
      0: it.answer_bound = 31'h7fff_ffff;
      1: it.answer_bound = 31'($urandom_range(0, 100));
      default: it.answer_bound = 31'($urandom());
    endcase
    case ($urandom_range(0, 9))
      0: it.divisor = '0;
      1, 2: it.divisor = 17'($urandom());
      default: it.divisor = 17'($urandom_range(1, 65536));
    endcase
    return it;
  endfunction

  // offers one item and waits for its transfer; valid stays high for a back-to-back item
  task automatic send_item(scau_pkg::in_item_t it);
    int unsigned gap;
    gap = draw_wait();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(predict_scaled_op(it));
  endtask

  task automatic test_unused_command();
    send_item(make_item(scau_pkg::CMD_NONE, 32'h7fff_ffff, -1, -1, -1, -1));
    send_item(make_item(scau_pkg::CMD_NONE, '0, '0, '0, 0, 0));
  endtask

  task automatic test_mult_add();
    send_item(make_item(scau_pkg::CMD_MULT_ADD, 3 << 16, 5, 1 << 16, 32'h7fff_ffff, 1));
    send_item(make_item(scau_pkg::CMD_MULT_ADD, -(7 << 16), -3, -5, 32'h7fff_ffff, 1));
    send_item(make_item(scau_pkg::CMD_MULT_ADD, 100, 2, 0, 200, 1));
    send_item(make_item(scau_pkg::CMD_MULT_ADD, 0, 1, 0, 0, 1));
    // zero multiplier passes the addend through without a bound check
    send_item(make_item(scau_pkg::CMD_MULT_ADD, 32'h7fff_ffff, 0, 32'h8000_0000, 0, 1));
    send_item(make_item(scau_pkg::CMD_MULT_ADD, 100, 2, 1, 200, 1));
    send_item(make_item(scau_pkg::CMD_MULT_ADD, 32'h7fff_ffff, 32'h7fff_ffff, 0,
                        32'h7fff_ffff, 1));
    send_item(make_item(scau_pkg::CMD_MULT_ADD, 32'h8000_0000, 1, 0, 32'h7fff_ffff, 1));
  endtask

  task automatic test_divide();
    send_item(make_item(scau_pkg::CMD_X_OVER_N, 100 << 16, 7, 0, 0, 0));
    send_item(make_item(scau_pkg::CMD_X_OVER_N, -(100 << 16) + 3, 7, 0, 0, 0));
    send_item(make_item(scau_pkg::CMD_X_OVER_N, 12345, -10, 0, 0, 0));
    send_item(make_item(scau_pkg::CMD_X_OVER_N, -12345, -10, 0, 0, 0));
    send_item(make_item(scau_pkg::CMD_X_OVER_N, -77, 0, 0, 0, 0));
    // quotient of 2^31 wraps without an error
    send_item(make_item(scau_pkg::CMD_X_OVER_N, 32'h8000_0000, -1, 0, 0, 0));
    send_item(make_item(scau_pkg::CMD_X_OVER_N, 32'h7fff_ffff, 1, 0, 0, 0));
    send_item(make_item(scau_pkg::CMD_X_OVER_N, 32'h8000_0000, 32'h7fff_ffff, 0, 0, 0));
  endtask

  task automatic test_xn_over_d();
    send_item(make_item(scau_pkg::CMD_XN_OVER_D, 3 << 16, 2, 0, 0, 3));
    send_item(make_item(scau_pkg::CMD_XN_OVER_D, -(5 << 16) - 1, 7, 0, 0, 9));
    send_item(make_item(scau_pkg::CMD_XN_OVER_D, 12345, 100, 0, 0, 0));
    send_item(make_item(scau_pkg::CMD_XN_OVER_D, 32'h7fff_ffff, 65536, 0, 0, 1));
    send_item(make_item(scau_pkg::CMD_XN_OVER_D, 32'h8000_0000, 65536, 0, 0, 65536));
    send_item(make_item(scau_pkg::CMD_XN_OVER_D, 32'h0123_4567, 1000, 0, 0, 32'h0001_ffff));
    send_item(make_item(scau_pkg::CMD_XN_OVER_D, 1000000, -3, 0, 0, 7));
    send_item(make_item(scau_pkg::CMD_XN_OVER_D, 32'h7fff_ffff, 0, 0, 0, 5));
  endtask

  task automatic test_random_mix(int count);
    for (int i = 0; i < count; i++) begin
      if (i % 100 == 0) no_idle = ($urandom_range(0, 3) == 0);
      send_item(rand_item());
    end
    no_idle = 1'b0;
  endtask

  task automatic test_back_to_back(int count);
    no_idle = 1'b1;
    for (int i = 0; i < count; i++) send_item(rand_item());
    no_idle = 1'b0;
  endtask

  // receiver holds off while items keep coming, so the block has to stall its input
  task automatic test_back_pressure(int count);
    hold_off_cycles = HOLD_OFF_LEN;
    for (int i = 0; i < count; i++) send_item(rand_item());
  endtask

  initial begin
    rst_ni           = 1'b0;
    in_valid         = 1'b0;
    in_item          = '0;
    out_ready        = 1'b0;
    exp_sticky_error = 1'b0;
    exp_remainder    = '0;
    fail_count       = 0;
    hold_off_cycles  = 0;
    no_idle          = 1'b0;
    repeat (6) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    test_unused_command();
    test_mult_add();
    test_divide();
    test_xn_over_d();
    test_random_mix(800);
    test_back_to_back(60);
    test_back_pressure(30);

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // result side: random stalls, compares every transfer with the oldest prediction
  initial begin : result_checker
    int unsigned         stall;
    scau_pkg::out_item_t exp;
    @(posedge clk iff rst_ni);
    forever begin
      if (hold_off_cycles != 0) begin
        stall           = hold_off_cycles;
        hold_off_cycles = 0;
      end else begin
        stall = draw_wait();
      end
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      if (pending_results.size() == 0) begin
        $error("result transfer with no item outstanding");
        fail_count++;
      end else begin
        exp = pending_results.pop_front();
        if (out_item.result !== exp.result) begin
          $error("result: expected %0d, got %0d", exp.result, out_item.result);
          fail_count++;
        end
        if (out_item.remainder_out !== exp.remainder_out) begin
          $error("remainder_out: expected %0d, got %0d", exp.remainder_out,
                 out_item.remainder_out);
          fail_count++;
        end
        if (out_item.op_error !== exp.op_error) begin
          $error("op_error: expected %0b, got %0b", exp.op_error, out_item.op_error);
          fail_count++;
        end
        if (out_item.error_seen !== exp.error_seen) begin
          $error("error_seen: expected %0b, got %0b", exp.error_seen, out_item.error_seen);
          fail_count++;
        end
      end
    end
  end

  // ends the run when no transfer happens on either side for too long
  always @(posedge clk) begin
    if (!rst_ni || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

`default_nettype wire
